// ----- src/waveform_min_max_rms_summary_top_assert.svh -----
// Assertion macros used by the checker file of the summary block.
`ifndef WAVEFORM_MIN_MAX_RMS_SUMMARY_TOP_ASSERT_SVH
`define WAVEFORM_MIN_MAX_RMS_SUMMARY_TOP_ASSERT_SVH

// The condition holds in the same cycle as the trigger, outside reset.
`define WMRS_CHK_IMPLY(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("summary block check failed");

// The condition holds in the cycle after the trigger, outside reset.
`define WMRS_CHK_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("summary block check failed");

// The condition holds in the cycle after the trigger, reset included.
`define WMRS_CHK_NEXT_ALWAYS(label, clk, trig, cond) \
  label: assert property (@(posedge clk) (trig) |=> (cond)) \
    else $error("summary block check failed");

`endif

// ----- src/wmrs_pkg.sv -----
`default_nettype none
package wmrs_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int FIELD_W     = 16;
  localparam int COUNT_W     = FIELD_W + 1;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic REG_BUCKET_SIZE = 1'b0;
  localparam logic REG_POINT_COUNT = 1'b1;

  localparam logic [FIELD_W-1:0] BUCKET_SIZE_RESET = 16'd1024;
  localparam logic [FIELD_W-1:0] POINT_COUNT_RESET = 16'd1024;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       new_buffer;
  } sample_t;

  typedef struct packed {
    logic [FIELD_W-1:0]         point_index;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic [FIELD_W-1:0]         rms_value;
  } result_t;

  typedef struct packed {
    logic [FIELD_W-1:0]         point_index;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic [COUNT_W-1:0]         count;
  } bucket_t;

endpackage
`default_nettype wire

// ----- src/wmrs_front.sv -----
`default_nettype none
module wmrs_front #(
  parameter int ACCUM_WIDTH = 48
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [wmrs_pkg::FIELD_W-1:0]    bucket_size,
  input  wire logic [wmrs_pkg::FIELD_W-1:0]    point_count,
  input  wire logic                            sample_valid,
  output logic                                 sample_ready,
  input  wire wmrs_pkg::sample_t               sample_data,
  input  wire logic                            full,
  output logic                                 push,
  output wmrs_pkg::bucket_t                    push_info,
  output logic [ACCUM_WIDTH-1:0]               push_sum
);

  localparam int SW    = wmrs_pkg::SAMPLE_W;
  localparam int FW    = wmrs_pkg::FIELD_W;
  localparam int MAG_W = SW + 1;
  localparam int SQ_W  = 2 * SW;

  logic [FW-1:0]          fill_count;
  logic [FW-1:0]          points_done;
  logic signed [SW-1:0]   running_min;
  logic signed [SW-1:0]   running_max;
  logic [ACCUM_WIDTH-1:0] square_sum;

  logic [FW-1:0]          eff_fill;
  logic [FW-1:0]          eff_points;
  logic signed [SW-1:0]   eff_min;
  logic signed [SW-1:0]   eff_max;
  logic [ACCUM_WIDTH-1:0] eff_sum;
  logic                   active;
  logic signed [SW-1:0]   min_next;
  logic signed [SW-1:0]   max_next;
  logic [MAG_W-1:0]       mag;
  logic [2*MAG_W-1:0]     product;
  logic [SQ_W-1:0]        square;
  logic [ACCUM_WIDTH:0]   sum_wide;
  logic [ACCUM_WIDTH-1:0] sum_next;
  logic [FW-1:0]          fill_next;
  logic [FW-1:0]          size;
  logic                   close;
  logic                   accept;

  assign sample_ready = !full;
  assign accept = sample_valid && sample_ready;

  always_comb begin
    eff_fill   = sample_data.new_buffer ? '0 : fill_count;
    eff_points = sample_data.new_buffer ? '0 : points_done;
    eff_min    = sample_data.new_buffer ? wmrs_pkg::SAMPLE_MAX : running_min;
    eff_max    = sample_data.new_buffer ? wmrs_pkg::SAMPLE_MIN : running_max;
    eff_sum    = sample_data.new_buffer ? '0 : square_sum;
    active     = eff_points < point_count;
    min_next   = (sample_data.sample < eff_min) ? sample_data.sample : eff_min;
    max_next   = (sample_data.sample > eff_max) ? sample_data.sample : eff_max;
    if (sample_data.sample[SW-1]) begin
      mag = MAG_W'(0) - {1'b1, sample_data.sample};
    end else begin
      mag = {1'b0, sample_data.sample};
    end
    product   = mag * mag;
    square    = product[SQ_W-1:0];
    sum_wide  = {1'b0, eff_sum} + (ACCUM_WIDTH+1)'(square);
    sum_next  = sum_wide[ACCUM_WIDTH] ? '1 : sum_wide[ACCUM_WIDTH-1:0];
    fill_next = eff_fill + FW'(1);
    size      = (bucket_size == '0) ? FW'(1) : bucket_size;
    close     = (fill_next == '0) || (fill_next >= size);
  end

  assign push = accept && active && close;

  always_comb begin
    push_info.point_index = eff_points;
    push_info.min_value   = min_next;
    push_info.max_value   = max_next;
    if (fill_next == '0) begin
      push_info.count = {1'b1, {FW{1'b0}}};
    end else begin
      push_info.count = {1'b0, fill_next};
    end
  end

  assign push_sum = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      points_done <= '0;
      running_min <= wmrs_pkg::SAMPLE_MAX;
      running_max <= wmrs_pkg::SAMPLE_MIN;
      square_sum  <= '0;
    end else if (accept) begin
      if (!active) begin
        fill_count  <= eff_fill;
        points_done <= eff_points;
        running_min <= eff_min;
        running_max <= eff_max;
        square_sum  <= eff_sum;
      end else if (close) begin
        fill_count  <= '0;
        points_done <= eff_points + FW'(1);
        running_min <= wmrs_pkg::SAMPLE_MAX;
        running_max <= wmrs_pkg::SAMPLE_MIN;
        square_sum  <= '0;
      end else begin
        fill_count  <= fill_next;
        points_done <= eff_points;
        running_min <= min_next;
        running_max <= max_next;
        square_sum  <= sum_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/wmrs_queue.sv -----
`default_nettype none
module wmrs_queue #(
  parameter int ACCUM_WIDTH = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire wmrs_pkg::bucket_t      push_info,
  input  wire logic [ACCUM_WIDTH-1:0] push_sum,
  input  wire logic                   pop,
  output wmrs_pkg::bucket_t           pop_info,
  output logic [ACCUM_WIDTH-1:0]      pop_sum,
  output logic                        full,
  output logic                        empty
);

  localparam int DEPTH = wmrs_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  wmrs_pkg::bucket_t      info_q [DEPTH];
  logic [ACCUM_WIDTH-1:0] sum_q  [DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       fill;

  assign full     = fill == CNT_W'(DEPTH);
  assign empty    = fill == '0;
  assign pop_info = info_q[rd_ptr];
  assign pop_sum  = sum_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      info_q[wr_ptr] <= push_info;
      sum_q[wr_ptr]  <= push_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/wmrs_back.sv -----
`default_nettype none
module wmrs_back #(
  parameter int ACCUM_WIDTH = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   empty,
  input  wire wmrs_pkg::bucket_t      pop_info,
  input  wire logic [ACCUM_WIDTH-1:0] pop_sum,
  output logic                        pop,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output wmrs_pkg::result_t           result_data
);

  localparam int CW     = wmrs_pkg::COUNT_W;
  localparam int FW     = wmrs_pkg::FIELD_W;
  localparam int ROOT_W = (ACCUM_WIDTH + 1) / 2;
  localparam int STEP_W = $clog2(ACCUM_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]             state;
  logic [STEP_W-1:0]      step;
  wmrs_pkg::bucket_t      info;
  logic [ACCUM_WIDTH-1:0] quot;
  logic [CW-1:0]          div_rem;
  logic [CW-1:0]          divisor;
  logic [2*ROOT_W-1:0]    radicand;
  logic [ROOT_W+1:0]      sq_rem;
  logic [ROOT_W-1:0]      root;

  logic [CW-1:0]          div_shift;
  logic                   div_ge;
  logic [ACCUM_WIDTH-1:0] quot_next;
  logic [ROOT_W+1:0]      sq_shift;
  logic [ROOT_W+1:0]      trial;
  logic                   sq_ge;
  logic                   load_out;

  always_comb begin
    div_shift = {div_rem[CW-2:0], quot[ACCUM_WIDTH-1]};
    div_ge    = div_shift >= divisor;
    quot_next = {quot[ACCUM_WIDTH-2:0], div_ge};
    sq_shift  = {sq_rem[ROOT_W-1:0], radicand[2*ROOT_W-1 -: 2]};
    trial     = {root, 2'b01};
    sq_ge     = sq_shift >= trial;
  end

  assign pop      = (state == ST_IDLE) && !empty;
  assign load_out = (state == ST_HOLD) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            state <= ST_DIV;
            step  <= STEP_W'(ACCUM_WIDTH - 1);
          end
        end
        ST_DIV: begin
          if (step == '0) begin
            state <= ST_SQRT;
            step  <= STEP_W'(ROOT_W - 1);
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        ST_SQRT: begin
          if (step == '0) begin
            state <= ST_HOLD;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        ST_HOLD: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        info    <= pop_info;
        quot    <= pop_sum;
        div_rem <= '0;
        divisor <= pop_info.count;
      end
      ST_DIV: begin
        div_rem <= div_ge ? div_shift - divisor : div_shift;
        quot    <= quot_next;
        if (step == '0) begin
          radicand <= (2*ROOT_W)'(quot_next);
          sq_rem   <= '0;
          root     <= '0;
        end
      end
      ST_SQRT: begin
        sq_rem   <= sq_ge ? sq_shift - trial : sq_shift;
        root     <= {root[ROOT_W-2:0], sq_ge};
        radicand <= {radicand[2*ROOT_W-3:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_data.point_index <= info.point_index;
      result_data.min_value   <= info.min_value;
      result_data.max_value   <= info.max_value;
      result_data.rms_value   <= root[FW-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- src/waveform_min_max_rms_summary_top.sv -----
// Samples are taken one per cycle; the front stalls only while two finished buckets wait.
// A bucket's result passes through the bit-serial divider and then the bit-serial root.
// The back end takes a new bucket only once the last result is in the output register.
// Synchronous reset clears the front counters and accumulators and the queue pointers,
// and restores both registers to 1024.
`default_nettype none
module waveform_min_max_rms_summary_top #(
  parameter int ACCUM_WIDTH = 48
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [wmrs_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [wmrs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [wmrs_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready,
  input  wire logic                                sample_valid,
  output logic                                     sample_ready,
  input  wire wmrs_pkg::sample_t                   sample_data,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output wmrs_pkg::result_t                        result_data
);

  localparam int FW = wmrs_pkg::FIELD_W;
  localparam int DW = wmrs_pkg::APB_DATA_W;

  logic [FW-1:0]          bucket_size;
  logic [FW-1:0]          point_count;
  logic                   push;
  logic                   pop;
  logic                   full;
  logic                   empty;
  wmrs_pkg::bucket_t      push_info;
  wmrs_pkg::bucket_t      pop_info;
  logic [ACCUM_WIDTH-1:0] push_sum;
  logic [ACCUM_WIDTH-1:0] pop_sum;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_size <= wmrs_pkg::BUCKET_SIZE_RESET;
      point_count <= wmrs_pkg::POINT_COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        wmrs_pkg::REG_BUCKET_SIZE: bucket_size <= pwdata[FW-1:0];
        wmrs_pkg::REG_POINT_COUNT: point_count <= pwdata[FW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      wmrs_pkg::REG_BUCKET_SIZE: prdata = DW'(bucket_size);
      wmrs_pkg::REG_POINT_COUNT: prdata = DW'(point_count);
      default:                   prdata = '0;
    endcase
  end

  wmrs_front #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .bucket_size  (bucket_size),
    .point_count  (point_count),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_data  (sample_data),
    .full         (full),
    .push         (push),
    .push_info    (push_info),
    .push_sum     (push_sum)
  );

  wmrs_queue #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_info (push_info),
    .push_sum  (push_sum),
    .pop       (pop),
    .pop_info  (pop_info),
    .pop_sum   (pop_sum),
    .full      (full),
    .empty     (empty)
  );

  wmrs_back #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop_info     (pop_info),
    .pop_sum      (pop_sum),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

endmodule
`default_nettype wire

// ----- src/wmrs_checker.sv -----
`default_nettype none
`include "waveform_min_max_rms_summary_top_assert.svh"
module wmrs_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire wmrs_pkg::result_t result_data
);

  `WMRS_CHK_NEXT(a_result_holds, clk, rst, result_valid && !result_ready, result_valid && $stable(result_data))
  `WMRS_CHK_IMPLY(a_rms_in_range, clk, rst, result_valid, result_data.rms_value <= 16'd32768)
  `WMRS_CHK_IMPLY(a_min_not_above_max, clk, rst, result_valid, result_data.min_value <= result_data.max_value)
  `WMRS_CHK_NEXT_ALWAYS(a_no_result_after_reset, clk, rst, !result_valid)

endmodule

bind waveform_min_max_rms_summary_top wmrs_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_data  (result_data)
);
`default_nettype wire

// ----- bench/waveform_min_max_rms_summary_top_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module waveform_min_max_rms_summary_top_tb;

  localparam int SETTLE_CYCLES  = 90;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint unsigned SQUARE_SUM_MAX = 64'h0000_FFFF_FFFF_FFFF;

  class summary_tracker;
    int unsigned bucket_len;
    int unsigned buffer_points;
    int unsigned fill;
    int unsigned points_done;
    int run_min;
    int run_max;
    longint unsigned square_sum;
    wmrs_pkg::result_t expected_points[$];
    int errors;

    function new();
      bucket_len = wmrs_pkg::BUCKET_SIZE_RESET;
      buffer_points = wmrs_pkg::POINT_COUNT_RESET;
      points_done = 0;
      errors = 0;
      clear_bucket();
    endfunction

    function void clear_bucket();
      fill = 0;
      run_min = 32767;
      run_max = -32768;
      square_sum = 0;
    endfunction

    function void set_register(logic sel, int unsigned value);
      if (sel == wmrs_pkg::REG_BUCKET_SIZE) begin
        bucket_len = value & 16'hFFFF;
      end else begin
        buffer_points = value & 16'hFFFF;
      end
    endfunction

    function int unsigned floor_root(longint unsigned v);
      int unsigned r;
      longint unsigned c;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        c = r | (1 << b);
        if (c * c <= v) begin
          r = c;
        end
      end
      return r;
    endfunction

    // Returns 1 when the sample was taken into a bucket, 0 when it was dropped.
    function bit note_sample(wmrs_pkg::sample_t s);
      int v;
      int unsigned span;
      longint unsigned sq;
      longint unsigned mean;
      wmrs_pkg::result_t pt;
      v = s.sample;
      if (s.new_buffer) begin
        points_done = 0;
        clear_bucket();
      end
      if (points_done >= buffer_points) begin
        return 0;
      end
      if (v < run_min) begin
        run_min = v;
      end
      if (v > run_max) begin
        run_max = v;
      end
      sq = longint'(v) * longint'(v);
      if (sq > SQUARE_SUM_MAX - square_sum) begin
        square_sum = SQUARE_SUM_MAX;
      end else begin
        square_sum += sq;
      end
      fill = (fill + 1) & 16'hFFFF;
      span = (bucket_len == 0) ? 1 : bucket_len;
      if (fill < span && fill != 0) begin
        return 1;
      end
      mean = square_sum / ((fill != 0) ? fill : 65536);
      pt.point_index = 16'(points_done);
      pt.min_value = 16'(run_min);
      pt.max_value = 16'(run_max);
      pt.rms_value = 16'(floor_root(mean));
      expected_points.push_back(pt);
      points_done = (points_done + 1) & 16'hFFFF;
      clear_bucket();
      return 1;
    endfunction

    function void check_point(wmrs_pkg::result_t got);
      wmrs_pkg::result_t want;
      if (expected_points.size() == 0) begin
        $error("unexpected result transfer, point_index %0d", got.point_index);
        errors++;
        return;
      end
      want = expected_points.pop_front();
      if (got.point_index !== want.point_index) begin
        $error("point_index: expected %0d, actual %0d", want.point_index, got.point_index);
        errors++;
      end
      if (got.min_value !== want.min_value) begin
        $error("min_value: expected %0d, actual %0d", want.min_value, got.min_value);
        errors++;
      end
      if (got.max_value !== want.max_value) begin
        $error("max_value: expected %0d, actual %0d", want.max_value, got.max_value);
        errors++;
      end
      if (got.rms_value !== want.rms_value) begin
        $error("rms_value: expected %0d, actual %0d", want.rms_value, got.rms_value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [wmrs_pkg::APB_ADDR_W-1:0] paddr;
  logic [wmrs_pkg::APB_DATA_W-1:0] pwdata;
  logic [wmrs_pkg::APB_DATA_W-1:0] prdata;
  logic pready;
  logic sample_valid;
  logic sample_ready;
  wmrs_pkg::sample_t sample_data;
  logic result_valid;
  logic result_ready;
  wmrs_pkg::result_t result_data;

  summary_tracker tracker;
  int counted;
  bit idle_on;
  int stall_left;
  int quiet_cycles;

  waveform_min_max_rms_summary_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      result_ready <= 1'b0;
      stall_left = $urandom_range(0, 17);
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      tracker.check_point(result_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_reg(logic sel, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_register(sel, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_sample(logic [15:0] v, bit nb);
    wmrs_pkg::sample_t s;
    s.sample = v;
    s.new_buffer = nb;
    @(negedge clk);
    sample_valid <= 1'b1;
    sample_data <= s;
    do @(posedge clk); while (!sample_ready);
    if (tracker.note_sample(s)) begin
      counted++;
    end
  endtask

  task automatic pause_input(int n);
    @(negedge clk);
    sample_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic input_gap();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pause_input($urandom_range(1, 18));
    end
  endtask

  // Waits until every predicted point has arrived and the back end has run dry.
  task automatic settle();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (tracker.expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] random_level();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_phase(int n_items);
    int goal;
    longint buf_len;
    goal = counted + n_items;
    while (counted < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          push_sample(random_level(), $urandom_range(0, 3) == 0);
          input_gap();
        end
      end else begin
        buf_len = longint'(tracker.bucket_len) * tracker.buffer_points + $urandom_range(0, 2);
        if (buf_len > goal - counted + 2) begin
          buf_len = goal - counted + 2;
        end
        for (longint i = 0; i < buf_len; i++) begin
          push_sample(random_level(), i == 0 || $urandom_range(0, 40) == 0);
          input_gap();
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_valid = 1'b0;
    sample_data = '0;
    result_ready = 1'b0;
    stall_left = 0;
    quiet_cycles = 0;
    counted = 0;
    idle_on = 1'b0;
    tracker = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(wmrs_pkg::REG_BUCKET_SIZE, 4);
    write_reg(wmrs_pkg::REG_POINT_COUNT, 3);
    push_sample(16'h7FFF, 1);
    push_sample(16'h7FFF, 0);
    push_sample(16'h8000, 0);
    push_sample(16'h0000, 0);
    repeat (4) push_sample(16'hFFFF, 0);
    repeat (4) push_sample(16'h8000, 0);
    // The buffer is complete, so these two are dropped.
    push_sample(16'd12345, 0);
    push_sample(16'd5, 0);
    // A new buffer flag in the middle of a bucket restarts it.
    push_sample(16'd100, 1);
    push_sample(16'd200, 0);
    push_sample(16'd300, 1);
    push_sample(16'd400, 0);
    push_sample(16'd500, 0);
    push_sample(16'd600, 0);
    push_sample(16'd7, 0);
    push_sample(-16'sd7, 0);
    settle();
    // Lowering the bucket size mid-bucket closes the bucket at the next sample.
    write_reg(wmrs_pkg::REG_BUCKET_SIZE, 1);
    push_sample(16'd9, 0);
    push_sample(-16'sd32767, 1);
    settle();

    idle_on = 1'b1;
    write_reg(wmrs_pkg::REG_BUCKET_SIZE, 65535);
    write_reg(wmrs_pkg::REG_POINT_COUNT, 65535);
    push_sample(random_level(), 1);
    repeat (11) begin
      push_sample(random_level(), 0);
      input_gap();
    end
    settle();
    write_reg(wmrs_pkg::REG_BUCKET_SIZE, 2);
    push_sample(random_level(), 0);
    settle();
    write_reg(wmrs_pkg::REG_BUCKET_SIZE, 1);
    run_phase(30);
    settle();

    while (counted < 480) begin
      case ($urandom_range(0, 3))
        0: begin
          write_reg(wmrs_pkg::REG_BUCKET_SIZE, $urandom_range(1, 3));
          write_reg(wmrs_pkg::REG_POINT_COUNT, 1);
        end
        1: begin
          write_reg(wmrs_pkg::REG_BUCKET_SIZE, $urandom_range(1, 12));
          write_reg(wmrs_pkg::REG_POINT_COUNT, $urandom_range(1, 8));
        end
        2: begin
          write_reg(wmrs_pkg::REG_BUCKET_SIZE, $urandom_range(1, 5));
          write_reg(wmrs_pkg::REG_POINT_COUNT, $urandom_range(1, 65535));
        end
        default: begin
          write_reg(wmrs_pkg::REG_BUCKET_SIZE, $urandom_range(6, 24));
          write_reg(wmrs_pkg::REG_POINT_COUNT, $urandom_range(2, 4));
        end
      endcase
      idle_on = $urandom_range(0, 3) != 0;
      run_phase($urandom_range(20, 50));
      settle();
    end

    idle_on = 1'b0;
    write_reg(wmrs_pkg::REG_BUCKET_SIZE, 3);
    write_reg(wmrs_pkg::REG_POINT_COUNT, 4);
    run_phase(70);
    settle();

    if (tracker.errors == 0 && tracker.expected_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/wmrs_pkg.sv
src/wmrs_front.sv
src/wmrs_queue.sv
src/wmrs_back.sv
src/waveform_min_max_rms_summary_top.sv
src/wmrs_checker.sv
bench/waveform_min_max_rms_summary_top_tb.sv
